@@ hdl/dghq_pkg.sv @@
// ----------------------------------------------------------------------------
// dghq_pkg
// Shared constants, codes and controller/datapath interface types for the
// graph hop query engine.
// ----------------------------------------------------------------------------
package dghq_pkg;

   // graph size; node fields are 6 bits, so at most 64 rows ever exist
   localparam int NODES  = 64;
   localparam int ROWS   = 64;
   localparam int ROW_W  = 64;
   localparam int NODE_W = 6;
   localparam int TYPE_W = 3;
   localparam int VALUE_W = 7;
   localparam int POP_STEPS = ROW_W / 8;
   localparam int POP_STEP_W = $clog2(POP_STEPS);

   localparam int LIVE_NODES = (NODES < ROWS) ? NODES : ROWS;
   localparam logic [NODE_W:0] LIVE_NODES_V = (NODE_W + 1)'(LIVE_NODES);
   localparam logic [ROW_W-1:0] LIVE_MASK =
      (LIVE_NODES >= ROW_W) ? {ROW_W{1'b1}}
                            : ((ROW_W'(1) << LIVE_NODES) - ROW_W'(1));
   localparam logic [VALUE_W-1:0] LEVEL_MAX = {VALUE_W{1'b1}};

   // request codes
   localparam logic [TYPE_W-1:0] OP_ADD     = 3'd0;
   localparam logic [TYPE_W-1:0] OP_REMOVE  = 3'd1;
   localparam logic [TYPE_W-1:0] OP_DEGREE  = 3'd2;
   localparam logic [TYPE_W-1:0] OP_TWOHOP  = 3'd3;
   localparam logic [TYPE_W-1:0] OP_DIST    = 3'd4;

   // read address select
   localparam logic [1:0] RD_SEL_A     = 2'd0;
   localparam logic [1:0] RD_SEL_B     = 2'd1;
   localparam logic [1:0] RD_SEL_SWEEP = 2'd2;

   // write row select
   localparam logic WR_SEL_A = 1'b0;
   localparam logic WR_SEL_B = 1'b1;

   // popcount source
   localparam logic POP_SRC_ROW = 1'b0;
   localparam logic POP_SRC_TWO = 1'b1;

   // pending result select
   localparam logic [1:0] RES_ZERO   = 2'd0;
   localparam logic [1:0] RES_NOCONN = 2'd1;
   localparam logic [1:0] RES_LEVEL  = 2'd2;
   localparam logic [1:0] RES_POP    = 2'd3;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       sweep_clr;
      logic       sweep_step;
      logic       th_load;
      logic       bfs_init;
      logic       bfs_advance;
      logic       pop_load;
      logic       pop_src;
      logic       pop_step;
      logic       res_set;
      logic [1:0] res_sel;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] op;
      logic              ok_a;
      logic              ok_b;
      logic              a_eq_b;
      logic              sweep_last;
      logic              frontier_zero;
      logic              hit_b;
      logic              level_max;
      logic              pop_last;
   } status_type;

endpackage

@@ hdl/dynamic_graph_hop_query_engine.sv @@
// ----------------------------------------------------------------------------
// dynamic_graph_hop_query_engine
// Undirected graph held as an adjacency bit matrix, with edge updates,
// degree, two-hop count and breadth-first hop distance requests.
// ----------------------------------------------------------------------------
// Add/remove requests give no result beat; they hold the engine while they
// read-modify-write two rows. A distance request makes one 64-row sweep of
// the RAM per search level. One request is in flight at a time; the next
// one is taken while a finished result still waits in the output register.
// Reset clears the per-row valid bits.
// ----------------------------------------------------------------------------
module dynamic_graph_hop_query_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dghq_pkg::TYPE_W-1:0]   req_type,
   input  logic [dghq_pkg::NODE_W-1:0]   req_node_a,
   input  logic [dghq_pkg::NODE_W-1:0]   req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dghq_pkg::VALUE_W-1:0]  rsp_value,
   output logic                          rsp_not_connected
);

   // command and status between sequencer and datapath
   dghq_pkg::cmd_type    cmd;
   dghq_pkg::status_type sts;

   // Sequencer: decode the request, walk rows, step search levels, and
   // hold the pending result until the output register is free.
   dghq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: row RAM with valid bits, sweep accumulator (OR of rows
   // selected by the frontier), visited/frontier sets, byte-serial popcount
   // and the result beat registers.
   dghq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_node_a        (req_node_a),
      .req_node_b        (req_node_b),
      .sts               (sts),
      .rsp_value         (rsp_value),
      .rsp_not_connected (rsp_not_connected)
   );

`ifndef SYNTHESIS
   // a row write only happens for a valid edge update between distinct nodes
   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> ((sts.op == dghq_pkg::OP_ADD || sts.op == dghq_pkg::OP_REMOVE)
                     && sts.ok_a && sts.ok_b && !sts.a_eq_b))
      else $error("row write outside a legal edge update");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result beat overwritten before it was taken");

   // after accepting a request the engine is busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted back to back");
`endif

endmodule

@@ hdl/dghq_ram.sv @@
// ----------------------------------------------------------------------------
// dghq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dghq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dghq_datapath.sv @@
// ----------------------------------------------------------------------------
// dghq_datapath
// Adjacency row store, row sweep accumulator, breadth-first sets, popcount
// and result registers.
// ----------------------------------------------------------------------------
module dghq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dghq_pkg::cmd_type               cmd,
   input  logic [dghq_pkg::TYPE_W-1:0]     req_type,
   input  logic [dghq_pkg::NODE_W-1:0]     req_node_a,
   input  logic [dghq_pkg::NODE_W-1:0]     req_node_b,
   output dghq_pkg::status_type            sts,
   output logic [dghq_pkg::VALUE_W-1:0]    rsp_value,
   output logic                            rsp_not_connected
);

   localparam int RW = dghq_pkg::ROW_W;
   localparam int NW = dghq_pkg::NODE_W;
   localparam int VW = dghq_pkg::VALUE_W;

   function automatic logic [3:0] count8(input logic [7:0] x);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'd0, x[i]};
      end
      return c;
   endfunction

   logic [dghq_pkg::TYPE_W-1:0] op_ff;
   logic [NW-1:0]               a_ff, b_ff;
   logic [dghq_pkg::ROWS-1:0]   valid_ff, valid_in;
   logic                        rd_vld_ff;
   logic [NW-1:0]               idx_ff;
   logic                        pend_ff;
   logic [NW-1:0]               pend_idx_ff;
   logic [RW-1:0]               row_ff, acc_ff, visited_ff, frontier_ff;
   logic [VW-1:0]               level_ff;
   logic [RW-1:0]               pop_sr_ff;
   logic [VW-1:0]               pop_cnt_ff;
   logic [dghq_pkg::POP_STEP_W-1:0] pop_step_ff;
   logic [VW-1:0]               res_value_ff, rsp_value_ff;
   logic                        res_nc_ff, rsp_nc_ff;

   logic [NW-1:0]  rd_addr, wr_addr;
   logic [RW-1:0]  rd_data, row_eff, wr_data, bit_a, bit_b, wr_bit;
   logic [RW-1:0]  next_set, two_set, pop_src_set;

   assign bit_a = RW'(1) << a_ff;
   assign bit_b = RW'(1) << b_ff;

   always_comb begin
      case (cmd.rd_sel)
         dghq_pkg::RD_SEL_A:     rd_addr = a_ff;
         dghq_pkg::RD_SEL_B:     rd_addr = b_ff;
         dghq_pkg::RD_SEL_SWEEP: rd_addr = idx_ff;
         default:                rd_addr = idx_ff;
      endcase
   end

   // rows never written read as empty
   assign row_eff = rd_vld_ff ? rd_data : '0;

   assign wr_addr = (cmd.wr_sel == dghq_pkg::WR_SEL_A) ? a_ff : b_ff;
   assign wr_bit  = (cmd.wr_sel == dghq_pkg::WR_SEL_A) ? bit_b : bit_a;
   assign wr_data = (op_ff == dghq_pkg::OP_ADD) ? (row_eff | wr_bit) : (row_eff & ~wr_bit);

   dghq_ram #(
      .WIDTH (RW),
      .DEPTH (dghq_pkg::ROWS)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign next_set    = acc_ff & dghq_pkg::LIVE_MASK & ~visited_ff;
   assign two_set     = acc_ff & dghq_pkg::LIVE_MASK & ~row_ff & ~bit_a;
   assign pop_src_set = (cmd.pop_src == dghq_pkg::POP_SRC_TWO) ? two_set : row_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= cmd.sweep_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_type;
         a_ff  <= req_node_a;
         b_ff  <= req_node_b;
      end
      if (cmd.rd_en) begin
         rd_vld_ff <= valid_ff[rd_addr];
      end
      // sweep: issue one row read a beat, fold in the row read last beat
      if (cmd.sweep_clr) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.sweep_step) begin
            idx_ff <= idx_ff + NW'(1);
         end
         if (pend_ff && frontier_ff[pend_idx_ff]) begin
            acc_ff <= acc_ff | row_eff;
         end
      end
      pend_idx_ff <= idx_ff;
      if (cmd.th_load) begin
         row_ff      <= row_eff;
         frontier_ff <= row_eff;
      end else if (cmd.bfs_init) begin
         visited_ff  <= bit_a;
         frontier_ff <= bit_a;
         level_ff    <= '0;
      end else if (cmd.bfs_advance) begin
         visited_ff  <= visited_ff | next_set;
         frontier_ff <= next_set;
         level_ff    <= level_ff + VW'(1);
      end
      if (cmd.pop_load) begin
         pop_sr_ff   <= pop_src_set;
         pop_cnt_ff  <= '0;
         pop_step_ff <= '0;
      end else if (cmd.pop_step) begin
         pop_sr_ff   <= pop_sr_ff >> 8;
         pop_cnt_ff  <= pop_cnt_ff + VW'(count8(pop_sr_ff[7:0]));
         pop_step_ff <= pop_step_ff + dghq_pkg::POP_STEP_W'(1);
      end
      if (cmd.res_set) begin
         case (cmd.res_sel)
            dghq_pkg::RES_ZERO: begin
               res_value_ff <= '0;
               res_nc_ff    <= 1'b0;
            end
            dghq_pkg::RES_NOCONN: begin
               res_value_ff <= '0;
               res_nc_ff    <= 1'b1;
            end
            dghq_pkg::RES_LEVEL: begin
               res_value_ff <= level_ff;
               res_nc_ff    <= 1'b0;
            end
            default: begin
               res_value_ff <= pop_cnt_ff;
               res_nc_ff    <= 1'b0;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_nc_ff    <= res_nc_ff;
      end
   end

   assign sts.op            = op_ff;
   assign sts.ok_a          = {1'b0, a_ff} < dghq_pkg::LIVE_NODES_V;
   assign sts.ok_b          = {1'b0, b_ff} < dghq_pkg::LIVE_NODES_V;
   assign sts.a_eq_b        = (a_ff == b_ff);
   assign sts.sweep_last    = (idx_ff == NW'(dghq_pkg::ROWS - 1));
   assign sts.frontier_zero = (frontier_ff == '0);
   assign sts.hit_b         = |(frontier_ff & bit_b);
   assign sts.level_max     = (level_ff == dghq_pkg::LEVEL_MAX);
   assign sts.pop_last      = (pop_step_ff == dghq_pkg::POP_STEP_W'(dghq_pkg::POP_STEPS - 1));

   assign rsp_value         = rsp_value_ff;
   assign rsp_not_connected = rsp_nc_ff;

endmodule

@@ hdl/dghq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dghq_ctrl
// Request sequencer: decodes each request and steps the datapath through
// row updates, row sweeps, search levels and popcounts.
// ----------------------------------------------------------------------------
module dghq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dghq_pkg::status_type  sts,
   output dghq_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_WR_A      = 4'd2;
   localparam logic [3:0] S_WR_B      = 4'd3;
   localparam logic [3:0] S_ROW_WAIT  = 4'd4;
   localparam logic [3:0] S_SWEEP     = 4'd5;
   localparam logic [3:0] S_DRAIN     = 4'd6;
   localparam logic [3:0] S_AFTER     = 4'd7;
   localparam logic [3:0] S_BFS_CHECK = 4'd8;
   localparam logic [3:0] S_POP       = 4'd9;
   localparam logic [3:0] S_POP_END   = 4'd10;
   localparam logic [3:0] S_FINISH    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.rd_sel = dghq_pkg::RD_SEL_A;
            case (sts.op)
               dghq_pkg::OP_ADD, dghq_pkg::OP_REMOVE: begin
                  if (sts.ok_a && sts.ok_b && !sts.a_eq_b) begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_WR_A;
                  end else begin
                     state_in  = S_IDLE;
                  end
               end
               dghq_pkg::OP_DEGREE, dghq_pkg::OP_TWOHOP: begin
                  if (sts.ok_a) begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_ROW_WAIT;
                  end else begin
                     cmd.res_set = 1'b1;
                     cmd.res_sel = dghq_pkg::RES_ZERO;
                     state_in    = S_FINISH;
                  end
               end
               dghq_pkg::OP_DIST: begin
                  if (sts.ok_a && sts.ok_b) begin
                     cmd.bfs_init = 1'b1;
                     state_in     = S_BFS_CHECK;
                  end else begin
                     cmd.res_set = 1'b1;
                     cmd.res_sel = dghq_pkg::RES_NOCONN;
                     state_in    = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WR_A: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = dghq_pkg::WR_SEL_A;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dghq_pkg::RD_SEL_B;
            state_in   = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = dghq_pkg::WR_SEL_B;
            state_in   = S_IDLE;
         end
         S_ROW_WAIT: begin
            if (sts.op == dghq_pkg::OP_DEGREE) begin
               cmd.pop_load = 1'b1;
               cmd.pop_src  = dghq_pkg::POP_SRC_ROW;
               state_in     = S_POP;
            end else begin
               cmd.th_load   = 1'b1;
               cmd.sweep_clr = 1'b1;
               state_in      = S_SWEEP;
            end
         end
         S_SWEEP: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = dghq_pkg::RD_SEL_SWEEP;
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_AFTER;
         end
         S_AFTER: begin
            if (sts.op == dghq_pkg::OP_TWOHOP) begin
               cmd.pop_load = 1'b1;
               cmd.pop_src  = dghq_pkg::POP_SRC_TWO;
               state_in     = S_POP;
            end else begin
               cmd.bfs_advance = 1'b1;
               state_in        = S_BFS_CHECK;
            end
         end
         S_BFS_CHECK: begin
            if (sts.frontier_zero || sts.level_max) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = dghq_pkg::RES_NOCONN;
               state_in    = S_FINISH;
            end else if (sts.hit_b) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = dghq_pkg::RES_LEVEL;
               state_in    = S_FINISH;
            end else begin
               cmd.sweep_clr = 1'b1;
               state_in      = S_SWEEP;
            end
         end
         S_POP: begin
            cmd.pop_step = 1'b1;
            if (sts.pop_last) begin
               state_in = S_POP_END;
            end
         end
         S_POP_END: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = dghq_pkg::RES_POP;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
